### sv/tcta_pkg.sv
`timescale 1ns / 1ps

package tcta_pkg;

  // event opcodes
  localparam logic [1:0] OP_BEG_REQ  = 2'd0;
  localparam logic [1:0] OP_END_REQ  = 2'd1;
  localparam logic [1:0] OP_BEG_RESP = 2'd2;
  localparam logic [1:0] OP_END_RESP = 2'd3;

  // result actions
  localparam logic [2:0] ACT_REQ      = 3'd0;
  localparam logic [2:0] ACT_END_REQ  = 3'd1;
  localparam logic [2:0] ACT_RESP     = 3'd2;
  localparam logic [2:0] ACT_END_RESP = 3'd3;
  localparam logic [2:0] ACT_QUEUED   = 3'd4;
  localparam logic [2:0] ACT_OVERFLOW = 3'd5;

  localparam int OQ_DEPTH = 4;

  typedef struct packed {
    logic [2:0]  action;
    logic [7:0]  tag;
    logic [1:0]  port;
    logic [31:0] seq;
    logic        last;
  } result_t;

  typedef struct packed {
    logic    wr0;
    logic    wr1;
    result_t r0;
    result_t r1;
  } outq_push_t;

  // Reduce a 2-bit index modulo n by repeated subtraction (at most 3 steps).
  function automatic logic [1:0] red_idx(input logic [1:0] v, input int unsigned n);
    logic [1:0] r;
    r = v;
    for (int i = 0; i < 3; i++) begin
      if (32'(r) >= n) begin
        r = r - 2'(n);
      end
    end
    return r;
  endfunction

endpackage

### sv/thread_channel_transaction_arbiter_core.sv
`timescale 1ns / 1ps

// Transaction arbiter between initiator threads and target channels.
// Event channel (evt_valid/evt_stall): one event per phase of the four-phase
// handshake of a transaction: opcode, tag, thread_index, channel_index.
// Result channel (res_valid/res_stall): action, out_tag, port, sequence_id,
// last. Each event gives one or two results; last marks the final one.
// The accept cycle issues the reads of the sequence RAM and of the tag RAM
// (queue head); the update state then does the read-modify-write of
// sequence number, queue pointers and busy flags.
// The block holds one event at a time; evt_stall is high in the update state.
// Both results of an event are written into the output queue in the update;
// the first is valid once registered there, the second once the first is taken.
// Results go into a 4-entry output queue; when the receiver stalls the queue
// fills, and the update cycle waits until two slots are free, so evt_stall
// stays high. Nothing is lost or repeated.
// Reset: all threads and channels idle, all queues empty, every sequence
// counter reads 1 (valid bits). Tag RAM contents need no clearing, so no
// init pass: the block accepts events as soon as reset is released.
module thread_channel_transaction_arbiter_core
  import tcta_pkg::*;
#(
  parameter int THREADS     = 4,
  parameter int CHANNELS    = 4,
  parameter int QUEUE_DEPTH = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        evt_valid,
  output logic        evt_stall,
  input  logic [1:0]  opcode,
  input  logic [7:0]  tag,
  input  logic [1:0]  thread_index,
  input  logic [1:0]  channel_index,
  output logic        res_valid,
  input  logic        res_stall,
  output logic [2:0]  action,
  output logic [7:0]  out_tag,
  output logic [1:0]  port,
  output logic [31:0] sequence_id,
  output logic        last
);

  localparam int TW     = (THREADS > 1) ? $clog2(THREADS) : 1;
  localparam int CIW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int QW     = $clog2(QUEUE_DEPTH);
  localparam int CW     = $clog2(QUEUE_DEPTH + 1);
  localparam int TDEPTH = (CHANNELS + THREADS) * QUEUE_DEPTH;
  localparam int TAW    = $clog2(TDEPTH);

  // FSM: accept (reads issued) then update
  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic             state;
  logic             accept;
  logic             go;
  logic             room;

  // latched event
  logic [1:0]       op_q;
  logic [7:0]       tag_q;
  logic [1:0]       th2_q;
  logic [1:0]       ch2_q;
  logic             seq_vld_q;

  // per-port control state
  logic             th_busy  [THREADS];
  logic             ch_busy  [CHANNELS];
  logic             seq_vld  [THREADS];
  logic [QW-1:0]    rq_head  [CHANNELS];
  logic [CW-1:0]    rq_cnt   [CHANNELS];
  logic [QW-1:0]    sq_head  [THREADS];
  logic [CW-1:0]    sq_cnt   [THREADS];

  // input-side decoded indices
  logic [1:0]       th2_in;
  logic [1:0]       ch2_in;
  logic [TW-1:0]    th_in;
  logic [CIW-1:0]   ch_in;
  logic [TW-1:0]    th_idx;
  logic [CIW-1:0]   ch_idx;

  // memories
  logic [TAW-1:0]   tag_rd_addr;
  logic [TAW-1:0]   tag_wr_addr;
  logic             tag_wr_en;
  logic [7:0]       tag_rd;
  logic             seq_wr_en;
  logic [31:0]      seq_rd;
  logic [31:0]      seq_cur;

  // update cycle signals
  logic [QW-1:0]    q_head;
  logic [CW-1:0]    q_cnt;
  logic [QW:0]      tail_sum;
  logic [QW-1:0]    tail_slot;
  logic [QW-1:0]    head_inc;
  logic             q_full;
  logic             q_empty;
  logic [TAW-1:0]   q_base;
  outq_push_t       push;
  result_t          head_res;

  assign accept    = evt_valid && !evt_stall;
  assign evt_stall = (state != ST_IDLE);
  assign go        = (state == ST_EXEC) && room;

  assign th2_in = red_idx(thread_index, THREADS);
  assign ch2_in = red_idx(channel_index, CHANNELS);
  assign th_in  = TW'(th2_in);
  assign ch_in  = CIW'(ch2_in);
  assign th_idx = TW'(th2_q);
  assign ch_idx = CIW'(ch2_q);

  // Pop reads: end request reads the channel's queue head, end response the
  // thread's. Request queues sit first in the tag RAM, response queues after.
  always_comb begin
    if (opcode == OP_END_RESP) begin
      tag_rd_addr = (TAW'(CHANNELS) + TAW'(th_in)) * TAW'(QUEUE_DEPTH)
                    + TAW'(sq_head[th_in]);
    end else begin
      tag_rd_addr = TAW'(ch_in) * TAW'(QUEUE_DEPTH) + TAW'(rq_head[ch_in]);
    end
  end

  tcta_ram #(
    .WIDTH (8),
    .DEPTH (TDEPTH)
  ) u_tag_ram (
    .clk     (clk),
    .wr_en   (tag_wr_en),
    .wr_addr (tag_wr_addr),
    .wr_data (tag_q),
    .rd_en   (accept),
    .rd_addr (tag_rd_addr),
    .rd_data (tag_rd)
  );

  tcta_ram #(
    .WIDTH (32),
    .DEPTH (THREADS)
  ) u_seq_ram (
    .clk     (clk),
    .wr_en   (seq_wr_en),
    .wr_addr (th_idx),
    .wr_data (seq_cur + 32'd1),
    .rd_en   (accept),
    .rd_addr (th_in),
    .rd_data (seq_rd)
  );

  // never-written counter reads as 1
  assign seq_cur = seq_vld_q ? seq_rd : 32'd1;

  // queue selected by the event: channel queue for requests,
  // thread queue for responses
  always_comb begin
    if (op_q[1]) begin
      q_head = sq_head[th_idx];
      q_cnt  = sq_cnt[th_idx];
      q_base = (TAW'(CHANNELS) + TAW'(th_idx)) * TAW'(QUEUE_DEPTH);
    end else begin
      q_head = rq_head[ch_idx];
      q_cnt  = rq_cnt[ch_idx];
      q_base = TAW'(ch_idx) * TAW'(QUEUE_DEPTH);
    end
    q_full   = (q_cnt == CW'(QUEUE_DEPTH));
    q_empty  = (q_cnt == '0);
    tail_sum = (QW+1)'(q_head) + (QW+1)'(q_cnt);
    if (tail_sum >= (QW+1)'(QUEUE_DEPTH)) begin
      tail_sum = tail_sum - (QW+1)'(QUEUE_DEPTH);
    end
    tail_slot = tail_sum[QW-1:0];
    if (q_head == QW'(QUEUE_DEPTH - 1)) begin
      head_inc = '0;
    end else begin
      head_inc = q_head + QW'(1);
    end
    tag_wr_addr = q_base + TAW'(tail_slot);
  end

  // result generation and write enables
  always_comb begin
    push      = '0;
    tag_wr_en = 1'b0;
    seq_wr_en = 1'b0;
    case (op_q)
      OP_BEG_REQ: begin
        seq_wr_en    = go;
        push.wr0     = go;
        push.r0.tag  = tag_q;
        push.r0.port = ch2_q;
        push.r0.seq  = seq_cur;
        push.r0.last = 1'b1;
        if (!ch_busy[ch_idx]) begin
          push.r0.action = ACT_REQ;
        end else if (!q_full) begin
          push.r0.action = ACT_QUEUED;
          tag_wr_en      = go;
        end else begin
          push.r0.action = ACT_OVERFLOW;
        end
      end
      OP_END_REQ: begin
        push.wr0       = go;
        push.r0.action = ACT_END_REQ;
        push.r0.tag    = tag_q;
        push.r0.port   = th2_q;
        push.r0.last   = q_empty;
        push.wr1       = go && !q_empty;
        push.r1.action = ACT_REQ;
        push.r1.tag    = tag_rd;
        push.r1.port   = ch2_q;
        push.r1.last   = 1'b1;
      end
      OP_BEG_RESP: begin
        push.wr0     = go;
        push.r0.tag  = tag_q;
        push.r0.port = th2_q;
        push.r0.last = 1'b1;
        if (!th_busy[th_idx]) begin
          push.r0.action = ACT_RESP;
        end else if (!q_full) begin
          push.r0.action = ACT_QUEUED;
          tag_wr_en      = go;
        end else begin
          push.r0.action = ACT_OVERFLOW;
        end
      end
      default: begin
        push.wr0       = go;
        push.r0.action = ACT_END_RESP;
        push.r0.tag    = tag_q;
        push.r0.port   = ch2_q;
        push.r0.last   = q_empty;
        push.wr1       = go && !q_empty;
        push.r1.action = ACT_RESP;
        push.r1.tag    = tag_rd;
        push.r1.port   = th2_q;
        push.r1.last   = 1'b1;
      end
    endcase
  end

  // event latch
  always_ff @(posedge clk) begin
    if (accept) begin
      op_q      <= opcode;
      tag_q     <= tag;
      th2_q     <= th2_in;
      ch2_q     <= ch2_in;
      seq_vld_q <= seq_vld[th_in];
    end
  end

  // FSM and per-port state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      for (int i = 0; i < THREADS; i++) begin
        th_busy[i] <= 1'b0;
        seq_vld[i] <= 1'b0;
        sq_head[i] <= '0;
        sq_cnt[i]  <= '0;
      end
      for (int i = 0; i < CHANNELS; i++) begin
        ch_busy[i] <= 1'b0;
        rq_head[i] <= '0;
        rq_cnt[i]  <= '0;
      end
    end else begin
      if (accept) begin
        state <= ST_EXEC;
      end else if (go) begin
        state <= ST_IDLE;
      end
      if (go) begin
        case (op_q)
          OP_BEG_REQ: begin
            seq_vld[th_idx] <= 1'b1;
            if (!ch_busy[ch_idx]) begin
              ch_busy[ch_idx] <= 1'b1;
            end else if (!q_full) begin
              rq_cnt[ch_idx] <= q_cnt + CW'(1);
            end
          end
          OP_END_REQ: begin
            if (q_empty) begin
              ch_busy[ch_idx] <= 1'b0;
            end else begin
              rq_head[ch_idx] <= head_inc;
              rq_cnt[ch_idx]  <= q_cnt - CW'(1);
            end
          end
          OP_BEG_RESP: begin
            if (!th_busy[th_idx]) begin
              th_busy[th_idx] <= 1'b1;
            end else if (!q_full) begin
              sq_cnt[th_idx] <= q_cnt + CW'(1);
            end
          end
          default: begin
            if (q_empty) begin
              th_busy[th_idx] <= 1'b0;
            end else begin
              sq_head[th_idx] <= head_inc;
              sq_cnt[th_idx]  <= q_cnt - CW'(1);
            end
          end
        endcase
      end
    end
  end

  tcta_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .room      (room),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .head_res  (head_res)
  );

  assign action      = head_res.action;
  assign out_tag     = head_res.tag;
  assign port        = head_res.port;
  assign sequence_id = head_res.seq;
  assign last        = head_res.last;

  a_accept_to_exec: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == ST_EXEC))
    else $error("accepted transaction did not enter update cycle");

  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EXEC) |-> (q_cnt <= CW'(QUEUE_DEPTH)))
    else $error("queue count beyond depth");

  a_launch_sets_busy: assert property (@(posedge clk) disable iff (rst)
    (go && (op_q == OP_BEG_REQ) && !ch_busy[ch_idx]) |=> ch_busy[$past(ch_idx)])
    else $error("launched request left channel idle");

  a_pop_only_nonempty: assert property (@(posedge clk) disable iff (rst)
    push.wr1 |-> (!q_empty && ((op_q == OP_END_REQ) || (op_q == OP_END_RESP))))
    else $error("queue pop without queued entry");

endmodule

### sv/tcta_ram.sv
`timescale 1ns / 1ps

module tcta_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                       clk,
  input  logic                                       wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                           wr_data,
  input  logic                                       rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                           rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### sv/tcta_outq.sv
`timescale 1ns / 1ps

module tcta_outq
  import tcta_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  outq_push_t push,
  output logic       room,
  output logic       res_valid,
  input  logic       res_stall,
  output result_t    head_res
);

  localparam int PW = $clog2(OQ_DEPTH);

  result_t         ent [OQ_DEPTH];
  logic [PW-1:0]   rd_ptr;
  logic [PW-1:0]   wr_ptr;
  logic [PW:0]     cnt;
  logic            pop;
  logic [PW:0]     n_push;

  assign res_valid = (cnt != '0);
  assign head_res  = ent[rd_ptr];
  assign pop       = res_valid && !res_stall;
  // two free slots needed: one event can give two results
  assign room      = (cnt <= (PW+1)'(OQ_DEPTH - 2));
  assign n_push    = (PW+1)'(push.wr0) + (PW+1)'(push.wr1);

  always_ff @(posedge clk) begin
    if (push.wr0) begin
      ent[wr_ptr] <= push.r0;
    end
    if (push.wr1) begin
      ent[wr_ptr + PW'(1)] <= push.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (pop) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      wr_ptr <= wr_ptr + n_push[PW-1:0];
      cnt    <= cnt + n_push - (PW+1)'(pop);
    end
  end

  a_no_overfill: assert property (@(posedge clk) disable iff (rst)
    push.wr0 |-> (cnt <= (PW+1)'(OQ_DEPTH - 2)))
    else $error("output queue written without room");

  a_second_needs_first: assert property (@(posedge clk) disable iff (rst)
    push.wr1 |-> push.wr0)
    else $error("second result pushed without first");

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= (PW+1)'(OQ_DEPTH))
    else $error("output queue count out of range");

endmodule

### tb/tb.sv
`timescale 1ns / 1ps

// Self-checking bench for the thread/channel transaction arbiter.
// A short directed table walks the corners: idle launch, a full request
// queue with overflow, launch from the queue, an unmatched end request, and
// a full response queue. A random part follows, mostly complete four-phase
// transactions mixed with fill-heavy and drain-heavy stretches of single
// events. Every accepted event is run through a local model of the arbiter.
// Every result is checked in order against that model or the row's own results.
module tb;
  import tcta_pkg::*;

  localparam int N_THREADS      = 4;
  localparam int N_CHANNELS     = 4;
  localparam int QDEPTH         = 8;
  localparam int RANDOM_EVENTS  = 1700;
  localparam int LONG_HOLD      = 120;  // receiver hold-off, in cycles
  localparam int HOLD_AFTER     = 400;  // results seen before the hold-off
  localparam int SETTLE_CYCLES  = 16;   // quiet time after the last result

  // One stimulus row. n == 0: result comes from the model; otherwise the
  // row carries its own expected results (the first always echoes tg).
  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  tg;
    logic [1:0]  th;
    logic [1:0]  ch;
    logic [1:0]  n;
    logic [2:0]  act0;
    logic [1:0]  port0;
    logic [31:0] seq0;
    logic [2:0]  act1;
    logic [7:0]  tag1;
    logic [1:0]  port1;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        evt_valid = 1'b0;
  logic        evt_stall;
  logic [1:0]  opcode = '0;
  logic [7:0]  tag = '0;
  logic [1:0]  thread_index = '0;
  logic [1:0]  channel_index = '0;
  logic        res_valid;
  logic        res_stall = 1'b0;
  logic [2:0]  action;
  logic [7:0]  out_tag;
  logic [1:0]  port;
  logic [31:0] sequence_id;
  logic        last;

  thread_channel_transaction_arbiter_core #(
    .THREADS    (N_THREADS),
    .CHANNELS   (N_CHANNELS),
    .QUEUE_DEPTH(QDEPTH)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .evt_valid    (evt_valid),
    .evt_stall    (evt_stall),
    .opcode       (opcode),
    .tag          (tag),
    .thread_index (thread_index),
    .channel_index(channel_index),
    .res_valid    (res_valid),
    .res_stall    (res_stall),
    .action       (action),
    .out_tag      (out_tag),
    .port         (port),
    .sequence_id  (sequence_id),
    .last         (last)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #2000000;
    $display("CHECK FAILED");
    $finish;
  end

  // ---- arbiter model state ----
  logic        thr_busy  [N_THREADS];
  logic        chan_busy [N_CHANNELS];
  logic [31:0] next_seq  [N_THREADS];
  logic [7:0]  req_slot  [N_CHANNELS][QDEPTH];
  int          req_head  [N_CHANNELS];
  int          req_cnt   [N_CHANNELS];
  logic [7:0]  resp_slot [N_THREADS][QDEPTH];
  int          resp_head [N_THREADS];
  int          resp_cnt  [N_THREADS];

  result_t pending_results[$];  // expected results, oldest first

  int events_sent   = 0;
  int results_seen  = 0;
  int mismatches    = 0;
  int burst_left    = 1;
  int act_count[6];
  bit long_hold_done = 1'b0;
  bit drain_pause_done = 1'b0;

  // Arbitrate one event against the model; returns the number of results.
  function automatic int arbitrate(input logic [1:0] op, input logic [7:0] tg,
                                   input logic [1:0] th, input logic [1:0] ch,
                                   output result_t r0, output result_t r1);
    int t;
    int c;
    int n;
    t = th % N_THREADS;
    c = ch % N_CHANNELS;
    r0 = '0;
    r1 = '0;
    r0.tag = tg;
    n = 1;
    case (op)
      OP_BEG_REQ: begin
        r0.port = 2'(c);
        r0.seq = next_seq[t];
        next_seq[t] = next_seq[t] + 32'd1;
        if (!chan_busy[c]) begin
          chan_busy[c] = 1'b1;
          r0.action = ACT_REQ;
        end else if (req_cnt[c] < QDEPTH) begin
          req_slot[c][(req_head[c] + req_cnt[c]) % QDEPTH] = tg;
          req_cnt[c]++;
          r0.action = ACT_QUEUED;
        end else begin
          r0.action = ACT_OVERFLOW;
        end
      end
      OP_END_REQ: begin
        r0.action = ACT_END_REQ;
        r0.port = 2'(t);
        if (req_cnt[c] != 0) begin
          // channel stays busy, oldest waiting request goes out unnumbered
          n = 2;
          r1.action = ACT_REQ;
          r1.tag = req_slot[c][req_head[c]];
          r1.port = 2'(c);
          req_head[c] = (req_head[c] + 1) % QDEPTH;
          req_cnt[c]--;
        end else begin
          chan_busy[c] = 1'b0;
        end
      end
      OP_BEG_RESP: begin
        r0.port = 2'(t);
        if (!thr_busy[t]) begin
          thr_busy[t] = 1'b1;
          r0.action = ACT_RESP;
        end else if (resp_cnt[t] < QDEPTH) begin
          resp_slot[t][(resp_head[t] + resp_cnt[t]) % QDEPTH] = tg;
          resp_cnt[t]++;
          r0.action = ACT_QUEUED;
        end else begin
          r0.action = ACT_OVERFLOW;
        end
      end
      OP_END_RESP: begin
        r0.action = ACT_END_RESP;
        r0.port = 2'(c);
        if (resp_cnt[t] != 0) begin
          n = 2;
          r1.action = ACT_RESP;
          r1.tag = resp_slot[t][resp_head[t]];
          r1.port = 2'(t);
          resp_head[t] = (resp_head[t] + 1) % QDEPTH;
          resp_cnt[t]--;
        end else begin
          thr_busy[t] = 1'b0;
        end
      end
    endcase
    if (n == 1) r0.last = 1'b1;
    else r1.last = 1'b1;
    return n;
  endfunction

  function automatic stim_row_t mk(input logic [1:0] op, input logic [7:0] tg,
                                   input logic [1:0] th, input logic [1:0] ch,
                                   input logic [1:0] n, input logic [2:0] act0,
                                   input logic [1:0] port0, input logic [31:0] seq0,
                                   input logic [2:0] act1, input logic [7:0] tag1,
                                   input logic [1:0] port1);
    stim_row_t r;
    r.op = op; r.tg = tg; r.th = th; r.ch = ch; r.n = n;
    r.act0 = act0; r.port0 = port0; r.seq0 = seq0;
    r.act1 = act1; r.tag1 = tag1; r.port1 = port1;
    return r;
  endfunction

  // Row checked against the model only.
  function automatic stim_row_t raw(input logic [1:0] op, input logic [7:0] tg,
                                    input logic [1:0] th, input logic [1:0] ch);
    return mk(op, tg, th, ch, 2'd0, ACT_REQ, 2'd0, 32'd0, ACT_REQ, 8'h00, 2'd0);
  endfunction

  // Offer one transaction, hold it until accepted, then log its results.
  // Sender runs in bursts; valid only drops when a gap follows.
  task automatic offer(input stim_row_t row);
    result_t p0;
    result_t p1;
    int n;
    int gap;
    opcode        <= row.op;
    tag           <= row.tg;
    thread_index  <= row.th;
    channel_index <= row.ch;
    evt_valid     <= 1'b1;
    do @(posedge clk); while (evt_stall);
    n = arbitrate(row.op, row.tg, row.th, row.ch, p0, p1);
    if (row.n != 0) begin
      n = row.n;
      p0 = '0;
      p0.action = row.act0;
      p0.tag    = row.tg;
      p0.port   = row.port0;
      p0.seq    = row.seq0;
      p0.last   = (row.n == 2'd1);
      p1 = '0;
      p1.action = row.act1;
      p1.tag    = row.tag1;
      p1.port   = row.port1;
      p1.last   = 1'b1;
    end
    pending_results.push_back(p0);
    if (n == 2) pending_results.push_back(p1);
    events_sent++;
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 6);
      if (gap > 0) begin
        evt_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // ---- result checker ----
  always @(posedge clk) begin : result_check
    result_t want;
    if (!rst && res_valid && !res_stall) begin
      results_seen++;
      if (action < 3'd6) act_count[action]++;
      if (pending_results.size() == 0) begin
        $error("unexpected result: action %0d tag %0h port %0d", action, out_tag, port);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (action !== want.action) begin
          $error("action: expected %0d, got %0d", want.action, action);
          mismatches++;
        end
        if (out_tag !== want.tag) begin
          $error("out_tag: expected %0h, got %0h", want.tag, out_tag);
          mismatches++;
        end
        if (port !== want.port) begin
          $error("port: expected %0d, got %0d", want.port, port);
          mismatches++;
        end
        if (sequence_id !== want.seq) begin
          $error("sequence_id: expected %0d, got %0d", want.seq, sequence_id);
          mismatches++;
        end
        if (last !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, last);
          mismatches++;
        end
      end
    end
  end

  // ---- receiver: stall pattern of its own, plus one long hold-off ----
  initial begin : receiver
    int mode;
    int span;
    while (rst) @(posedge clk);
    forever begin
      if (!long_hold_done && results_seen >= HOLD_AFTER) begin
        // output queue fills, block must stall its event input
        long_hold_done = 1'b1;
        res_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
      end
      mode = $urandom_range(0, 3);
      span = $urandom_range(8, 60);
      repeat (span) begin
        case (mode)
          0:       res_stall <= 1'b0;
          1:       res_stall <= ($urandom_range(0, 1) == 0);
          2:       res_stall <= ($urandom_range(0, 3) == 0);
          default: res_stall <= ($urandom_range(0, 3) != 0);
        endcase
        @(posedge clk);
      end
    end
  end

  // ---- stimulus ----
  initial begin : stimulus
    stim_row_t directed[$];
    int sent;
    int phase;
    int r;
    logic [1:0] op;
    logic [7:0] tg;
    logic [1:0] th;
    logic [1:0] ch;

    for (int i = 0; i < N_THREADS; i++) begin
      thr_busy[i] = 1'b0;
      next_seq[i] = 32'd1;
      resp_head[i] = 0;
      resp_cnt[i] = 0;
    end
    for (int i = 0; i < N_CHANNELS; i++) begin
      chan_busy[i] = 1'b0;
      req_head[i] = 0;
      req_cnt[i] = 0;
    end
    for (int i = 0; i < 6; i++) act_count[i] = 0;
    burst_left = $urandom_range(1, 24);

    // idle channels launch at once, first number of each thread is 1
    directed.push_back(mk(OP_BEG_REQ, 8'h00, 2'd0, 2'd0, 2'd1,
                          ACT_REQ, 2'd0, 32'd1, ACT_REQ, 8'h00, 2'd0));
    directed.push_back(mk(OP_BEG_REQ, 8'hFF, 2'd3, 2'd3, 2'd1,
                          ACT_REQ, 2'd3, 32'd1, ACT_REQ, 8'h00, 2'd0));
    // fill channel 0's queue, one tag bit per entry
    for (int i = 0; i < QDEPTH; i++)
      directed.push_back(mk(OP_BEG_REQ, 8'(1 << i), 2'd1, 2'd0, 2'd1,
                            ACT_QUEUED, 2'd0, 32'(i + 1), ACT_REQ, 8'h00, 2'd0));
    // full queue: number still used up, request dropped
    directed.push_back(mk(OP_BEG_REQ, 8'hAA, 2'd1, 2'd0, 2'd1,
                          ACT_OVERFLOW, 2'd0, 32'd9, ACT_REQ, 8'h00, 2'd0));
    // end request releases the oldest waiting request
    directed.push_back(mk(OP_END_REQ, 8'h00, 2'd0, 2'd0, 2'd2,
                          ACT_END_REQ, 2'd0, 32'd0, ACT_REQ, 8'h01, 2'd0));
    // empty queue: channel goes idle
    directed.push_back(mk(OP_END_REQ, 8'hFF, 2'd3, 2'd3, 2'd1,
                          ACT_END_REQ, 2'd3, 32'd0, ACT_REQ, 8'h00, 2'd0));
    // end request on a channel that was never busy
    directed.push_back(mk(OP_END_REQ, 8'h5A, 2'd2, 2'd2, 2'd1,
                          ACT_END_REQ, 2'd2, 32'd0, ACT_REQ, 8'h00, 2'd0));
    directed.push_back(mk(OP_BEG_RESP, 8'h11, 2'd2, 2'd1, 2'd1,
                          ACT_RESP, 2'd2, 32'd0, ACT_REQ, 8'h00, 2'd0));
    for (int i = 0; i < QDEPTH; i++)
      directed.push_back(raw(OP_BEG_RESP, ~8'(1 << i), 2'd2, 2'd1));
    directed.push_back(mk(OP_BEG_RESP, 8'h33, 2'd2, 2'd1, 2'd1,
                          ACT_OVERFLOW, 2'd2, 32'd0, ACT_REQ, 8'h00, 2'd0));
    // end response goes to the channel, then the next waiting response
    directed.push_back(mk(OP_END_RESP, 8'h11, 2'd2, 2'd1, 2'd2,
                          ACT_END_RESP, 2'd1, 32'd0, ACT_RESP, 8'hFE, 2'd2));

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (directed[i]) offer(directed[i]);

    // Random part. Phases of 300 events: fill-heavy, drain-heavy, uniform.
    // Most traffic is whole four-phase transactions with random content.
    sent = 0;
    while (sent < RANDOM_EVENTS) begin
      if (!drain_pause_done && sent >= RANDOM_EVENTS / 2) begin
        // sender holds off until every outstanding result is back
        drain_pause_done = 1'b1;
        evt_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
      end
      phase = (sent / 300) % 3;
      tg = 8'($urandom_range(0, 255));
      th = 2'($urandom_range(0, 3));
      ch = 2'($urandom_range(0, 3));
      if ($urandom_range(0, 9) < 6) begin
        offer(raw(OP_BEG_REQ, tg, th, ch));
        offer(raw(OP_END_REQ, tg, th, ch));
        offer(raw(OP_BEG_RESP, tg, th, ch));
        offer(raw(OP_END_RESP, tg, th, ch));
        sent += 4;
      end else begin
        r = $urandom_range(0, 9);
        if (phase == 2) begin
          op = 2'($urandom_range(0, 3));
        end else if ((phase == 0) ? (r < 9) : (r == 0)) begin
          op = $urandom_range(0, 1) ? OP_BEG_REQ : OP_BEG_RESP;
        end else begin
          op = $urandom_range(0, 1) ? OP_END_REQ : OP_END_RESP;
        end
        offer(raw(op, tg, th, ch));
        sent++;
      end
    end
    evt_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Covered %0d transactions, %0d results checked, long receiver hold-off: %0b",
             events_sent, results_seen, long_hold_done);
    $display("  req %0d, req_done %0d, resp %0d, resp_done %0d, queued %0d, overflow %0d",
             act_count[ACT_REQ], act_count[ACT_END_REQ], act_count[ACT_RESP],
             act_count[ACT_END_RESP], act_count[ACT_QUEUED], act_count[ACT_OVERFLOW]);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
